/* rtl/ola_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ola_pkg: shared types, codes and fixed-point helpers
// Word layouts for both channels, operator and status codes, and the
// truncating Q1.16 multiply, saturate and uncertainty helpers.
// ---------------------------------------------------------------------------
package ola_pkg;

	localparam int FRAC_BITS = 16;
	localparam int VAL_W     = FRAC_BITS + 1;
	localparam int EXT_W     = VAL_W + 1;
	localparam int ACC_W     = VAL_W + 3;
	localparam logic [VAL_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;

	// operator codes
	localparam logic [2:0] FN_AND  = 3'd0;
	localparam logic [2:0] FN_OR   = 3'd1;
	localparam logic [2:0] FN_ADD  = 3'd2;
	localparam logic [2:0] FN_SUB  = 3'd3;
	localparam logic [2:0] FN_NEG  = 3'd4;
	localparam logic [2:0] FN_CMP  = 3'd5;
	localparam logic [2:0] FN_NONE = 3'd7;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_DIV0  = 2'd2;

	typedef struct packed {
		logic [2:0]       func;
		logic [VAL_W-1:0] a_belief;
		logic [VAL_W-1:0] a_disbelief;
		logic [VAL_W-1:0] a_base_rate;
		logic [VAL_W-1:0] b_belief;
		logic [VAL_W-1:0] b_disbelief;
		logic [VAL_W-1:0] b_base_rate;
	} req_t;

	typedef struct packed {
		logic [VAL_W-1:0] out_belief;
		logic [VAL_W-1:0] out_disbelief;
		logic [VAL_W-1:0] out_uncertainty;
		logic [VAL_W-1:0] out_base_rate;
		logic [VAL_W-1:0] out_expectation;
		logic [1:0]       status;
		logic             less_than;
	} rsp_t;

	// classified operand word handed from front to back
	typedef struct packed {
		logic [2:0]       func;
		logic             add_oor;
		logic [VAL_W-1:0] aa;
		logic [VAL_W-1:0] ba;
		logic [VAL_W-1:0] ab;
		logic [VAL_W-1:0] bb;
		logic [VAL_W-1:0] ad;
		logic [VAL_W-1:0] bd;
		logic [VAL_W-1:0] au;
		logic [VAL_W-1:0] bu;
	} fe_t;

	function automatic logic [VAL_W-1:0] sat1(input logic [VAL_W-1:0] x);
		return (x > ONE) ? ONE : x;
	endfunction

	function automatic logic [VAL_W-1:0] unc(input logic [VAL_W-1:0] b,
			input logic [VAL_W-1:0] d);
		logic [VAL_W:0] s;
		s = {1'b0, b} + {1'b0, d};
		if (s > {1'b0, ONE})
			return '0;
		return VAL_W'({1'b0, ONE} - s);
	endfunction

	// truncating product of two nonnegative values
	function automatic logic [EXT_W-1:0] mul_u(input logic [EXT_W-1:0] x,
			input logic [EXT_W-1:0] y);
		logic [2*EXT_W-1:0] p;
		p = x * y;
		return p[FRAC_BITS +: EXT_W];
	endfunction

	// product truncated toward zero, second operand signed
	function automatic logic signed [EXT_W:0] mul_s(input logic [EXT_W-1:0] x,
			input logic signed [EXT_W:0] y);
		logic [EXT_W-1:0] ym;
		logic [EXT_W-1:0] p;
		ym = y[EXT_W] ? EXT_W'(-y) : EXT_W'(y);
		p  = mul_u(x, ym);
		return y[EXT_W] ? -$signed({1'b0, p}) : $signed({1'b0, p});
	endfunction

	function automatic logic [VAL_W-1:0] sat_s(input logic signed [ACC_W-1:0] x);
		if (x < 0)
			return '0;
		if (x > $signed({3'b0, ONE}))
			return ONE;
		return x[VAL_W-1:0];
	endfunction

endpackage
`default_nettype wire

/* rtl/ola_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ola_front: request intake and classification
// Saturates operands, derives both uncertainties, checks the add range and
// maps operator codes, then hands the word to the queue.
// ---------------------------------------------------------------------------
module ola_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	input  ola_pkg::req_t      req,
	output logic               req_stall,
	input  wire logic          q_full,
	output logic               q_push,
	output ola_pkg::fe_t       fe
);

	ola_pkg::fe_t fe_d;
	ola_pkg::fe_t fe_s1;
	logic         fe_v_s1;
	logic [ola_pkg::VAL_W:0] sum_a;
	logic [ola_pkg::VAL_W:0] sum_b;

	// saturate inputs and classify the operator
	always_comb begin
		fe_d.aa = ola_pkg::sat1(req.a_base_rate);
		fe_d.ba = ola_pkg::sat1(req.b_base_rate);
		fe_d.ab = ola_pkg::sat1(req.a_belief);
		fe_d.bb = ola_pkg::sat1(req.b_belief);
		fe_d.ad = ola_pkg::sat1(req.a_disbelief);
		fe_d.bd = ola_pkg::sat1(req.b_disbelief);
		fe_d.au = ola_pkg::unc(fe_d.ab, fe_d.ad);
		fe_d.bu = ola_pkg::unc(fe_d.bb, fe_d.bd);
		sum_a = {1'b0, fe_d.aa} + {1'b0, fe_d.ba};
		sum_b = {1'b0, fe_d.ab} + {1'b0, fe_d.bb};
		fe_d.add_oor = (sum_a > {1'b0, ola_pkg::ONE}) || (sum_b > {1'b0, ola_pkg::ONE});
		case (req.func)
			ola_pkg::FN_AND: fe_d.func = ola_pkg::FN_AND;
			ola_pkg::FN_OR:  fe_d.func = ola_pkg::FN_OR;
			ola_pkg::FN_ADD: fe_d.func = ola_pkg::FN_ADD;
			ola_pkg::FN_SUB: fe_d.func = ola_pkg::FN_SUB;
			ola_pkg::FN_NEG: fe_d.func = ola_pkg::FN_NEG;
			ola_pkg::FN_CMP: fe_d.func = ola_pkg::FN_CMP;
			default:         fe_d.func = ola_pkg::FN_NONE;
		endcase
	end

	assign req_stall = fe_v_s1 && q_full;
	assign q_push    = fe_v_s1 && !q_full;
	assign fe        = fe_s1;

	// hold the word until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fe_v_s1 <= 1'b0;
		end else if (!req_stall) begin
			fe_v_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			fe_s1 <= fe_d;
		end
	end

endmodule
`default_nettype wire

/* rtl/ola_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ola_queue: decoupling queue between front and back
// Small circular buffer of classified words; lets each side stall alone.
// ---------------------------------------------------------------------------
module ola_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  ola_pkg::fe_t       din,
	output logic               full,
	input  wire logic          pop,
	output ola_pkg::fe_t       dout,
	output logic               empty
);

	ola_pkg::fe_t                  mem_q [ola_pkg::QDEPTH];
	logic [ola_pkg::QPTR_W-1:0]    wr_q;
	logic [ola_pkg::QPTR_W-1:0]    rd_q;
	logic [ola_pkg::QPTR_W:0]      cnt_q;
	logic                          do_pop;

	assign full   = (cnt_q == (ola_pkg::QPTR_W+1)'(ola_pkg::QDEPTH));
	assign empty  = (cnt_q == '0);
	assign do_pop = pop && !empty;
	assign dout   = mem_q[rd_q];

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (do_pop)
				rd_q <= rd_q + 1'b1;
			if (push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (!push && do_pop)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (ola_pkg::QPTR_W+1)'(ola_pkg::QDEPTH))
		else $error("queue fill count beyond depth");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into full queue");

endmodule
`default_nettype wire

/* rtl/ola_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ola_back: operator execution pipeline
// Product stages, a one-bit-per-stage restoring divider, result assembly,
// saturation and expectation, ending in the response register.
// ---------------------------------------------------------------------------
module ola_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_empty,
	input  ola_pkg::fe_t       q_head,
	output logic               q_pop,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output ola_pkg::rsp_t      rsp
);

	localparam int W = ola_pkg::VAL_W;
	localparam int X = ola_pkg::EXT_W;
	localparam int R = ola_pkg::ACC_W;

	typedef struct packed {
		ola_pkg::fe_t       f;
		logic [X-1:0]       x1;
		logic [X-1:0]       x2;
		logic [X-1:0]       pab;
		logic [X-1:0]       pbb;
		logic [X-1:0]       pdd;
		logic [X-1:0]       ss1;
		logic [X-1:0]       ca;
		logic [X-1:0]       cb;
		logic signed [X:0]  sa1;
		logic signed [X:0]  sa2;
		logic signed [X:0]  ss2;
	} b1_t;

	typedef struct packed {
		ola_pkg::fe_t        f;
		logic [X-1:0]        m1;
		logic [X-1:0]        m2;
		logic [X-1:0]        pab;
		logic [X-1:0]        pbb;
		logic [X-1:0]        pdd;
		logic [X-1:0]        den;
		logic signed [R-1:0] nas;
		logic                lt;
	} b2_t;

	typedef struct packed {
		logic [2:0]   func;
		logic         lt;
		logic         range;
		logic         div0;
		logic         neg;
		logic         ovf;
		logic [W-1:0] ab;
		logic [W-1:0] bb;
		logic [W-1:0] ad;
		logic [W-1:0] bd;
		logic [W-1:0] aa;
		logic [X-1:0] pab;
		logic [X-1:0] pbb;
		logic [X-1:0] pdd;
		logic [X-1:0] den;
	} carry_t;

	typedef struct packed {
		carry_t       c;
		logic [R-1:0] r;
		logic [W-1:0] q;
	} dv_t;

	typedef struct packed {
		logic [W-1:0] b;
		logic [W-1:0] d;
		logic [W-1:0] a;
		logic [W-1:0] u;
		logic [1:0]   status;
		logic         lt;
	} fin_t;

	typedef struct packed {
		fin_t         v;
		logic [X-1:0] prod;
	} f2_t;

	function automatic dv_t div_step(input dv_t d, input logic first);
		dv_t          o;
		logic [R-1:0] t;
		logic [R-1:0] dd;
		o  = d;
		t  = first ? d.r : {d.r[R-2:0], 1'b0};
		dd = {2'b0, d.c.den};
		if (t >= dd) begin
			o.r = t - dd;
			o.q = {d.q[W-2:0], 1'b1};
		end else begin
			o.r = t;
			o.q = {d.q[W-2:0], 1'b0};
		end
		return o;
	endfunction

	logic          en;
	logic          rsp_v_q;
	ola_pkg::rsp_t rsp_q;

	b1_t    b1_d, b1_s1;
	b2_t    b2_d, b2_s2, b3_d, b3_s3;
	dv_t    b4_d, b4_s4;
	dv_t    dv_s [1:W];
	logic   dv_v [1:W];
	fin_t   f1_d, f1_s5;
	f2_t    f2_s6;
	logic   b1_v_s1, b2_v_s2, b3_v_s3, b4_v_s4, f1_v_s5, f2_v_s6;

	logic [X-1:0]        ea, eb, sum_z;
	logic signed [R-1:0] n4;
	logic [R-1:0]        mag4;
	logic [X-1:0]        qc;
	logic signed [R-1:0] qadd, qs, rb, rd, ra;
	logic                val;
	logic                is_and;
	logic                is_and3;

	assign en        = !rsp_v_q || !rsp_stall;
	assign q_pop     = en && !q_empty;
	assign rsp_valid = rsp_v_q;
	assign rsp       = rsp_q;

	// stage 1: first-level products
	always_comb begin
		b1_d.f   = q_head;
		b1_d.x1  = ola_pkg::mul_u({1'b0, ola_pkg::ONE - q_head.aa}, {1'b0, q_head.ba});
		b1_d.x2  = ola_pkg::mul_u({1'b0, q_head.aa}, {1'b0, ola_pkg::ONE - q_head.ba});
		b1_d.pab = ola_pkg::mul_u({1'b0, q_head.aa}, {1'b0, q_head.ba});
		b1_d.pbb = ola_pkg::mul_u({1'b0, q_head.ab}, {1'b0, q_head.bb});
		b1_d.pdd = ola_pkg::mul_u({1'b0, q_head.ad}, {1'b0, q_head.bd});
		b1_d.ss1 = ola_pkg::mul_u({1'b0, q_head.aa}, {1'b0, q_head.ad} + {1'b0, q_head.bb});
		b1_d.ca  = ola_pkg::mul_u({1'b0, q_head.aa}, {1'b0, q_head.au});
		b1_d.cb  = ola_pkg::mul_u({1'b0, q_head.ba}, {1'b0, q_head.bu});
		b1_d.sa1 = ola_pkg::mul_s({1'b0, q_head.aa},
			$signed({2'b0, q_head.ad}) - $signed({2'b0, q_head.bb}));
		b1_d.sa2 = ola_pkg::mul_s({1'b0, q_head.ba},
			$signed({2'b0, q_head.bd}) - $signed({2'b0, q_head.ab}));
		b1_d.ss2 = ola_pkg::mul_s({1'b0, q_head.ba},
			$signed({2'b0, ola_pkg::ONE}) + $signed({2'b0, q_head.bb})
			- $signed({2'b0, q_head.ab}) - $signed({2'b0, q_head.bu}));
	end

	// stage 2: second products, add/sub numerators, divisor, compare
	always_comb begin
		is_and   = (b1_s1.f.func == ola_pkg::FN_AND);
		b2_d.f   = b1_s1.f;
		b2_d.pab = b1_s1.pab;
		b2_d.pbb = b1_s1.pbb;
		b2_d.pdd = b1_s1.pdd;
		b2_d.m1  = ola_pkg::mul_u(is_and ? b1_s1.x1 : b1_s1.x2,
			is_and ? {1'b0, b1_s1.f.ab} : {1'b0, b1_s1.f.ad});
		b2_d.m2  = ola_pkg::mul_u(is_and ? b1_s1.x2 : b1_s1.x1, {1'b0, b1_s1.f.au});
		b2_d.nas = '0;
		b2_d.den = '0;
		case (b1_s1.f.func)
			ola_pkg::FN_AND: b2_d.den = {1'b0, ola_pkg::ONE} - b1_s1.pab;
			ola_pkg::FN_OR:  b2_d.den = {1'b0, b1_s1.f.aa} + {1'b0, b1_s1.f.ba} - b1_s1.pab;
			ola_pkg::FN_ADD: begin
				b2_d.den = {1'b0, b1_s1.f.aa} + {1'b0, b1_s1.f.ba};
				b2_d.nas = R'(b1_s1.sa1) + R'(b1_s1.sa2);
			end
			ola_pkg::FN_SUB: begin
				b2_d.den = {1'b0, b1_s1.f.aa} - {1'b0, b1_s1.f.ba};
				b2_d.nas = $signed({2'b0, b1_s1.ss1}) - R'(b1_s1.ss2);
			end
			default: ;
		endcase
		ea = {1'b0, b1_s1.f.ab} + b1_s1.ca;
		eb = {1'b0, b1_s1.f.bb} + b1_s1.cb;
		priority if (ea != eb)
			b2_d.lt = (ea < eb);
		else if (b1_s1.f.au != b1_s1.f.bu)
			b2_d.lt = (b1_s1.f.au > b1_s1.f.bu);
		else
			b2_d.lt = (b1_s1.f.aa > b1_s1.f.ba);
	end

	// stage 3: third products for and/or numerators
	always_comb begin
		is_and3 = (b2_s2.f.func == ola_pkg::FN_AND);
		b3_d    = b2_s2;
		b3_d.m1 = ola_pkg::mul_u(b2_s2.m1, {1'b0, b2_s2.f.bu});
		b3_d.m2 = ola_pkg::mul_u(b2_s2.m2,
			is_and3 ? {1'b0, b2_s2.f.bb} : {1'b0, b2_s2.f.bd});
	end

	// stage 4: numerator, range and divisor checks, divider setup
	always_comb begin
		sum_z = b3_s3.m1 + b3_s3.m2;
		if (b3_s3.f.func == ola_pkg::FN_AND || b3_s3.f.func == ola_pkg::FN_OR)
			n4 = $signed({2'b0, sum_z});
		else
			n4 = b3_s3.nas;
		mag4 = n4[R-1] ? R'(-n4) : R'(n4);
		b4_d.c.func = b3_s3.f.func;
		b4_d.c.lt   = b3_s3.lt;
		b4_d.c.neg  = n4[R-1];
		b4_d.c.ab   = b3_s3.f.ab;
		b4_d.c.bb   = b3_s3.f.bb;
		b4_d.c.ad   = b3_s3.f.ad;
		b4_d.c.bd   = b3_s3.f.bd;
		b4_d.c.aa   = b3_s3.f.aa;
		b4_d.c.pab  = b3_s3.pab;
		b4_d.c.pbb  = b3_s3.pbb;
		b4_d.c.pdd  = b3_s3.pdd;
		b4_d.c.den  = b3_s3.den;
		b4_d.c.div0 = (b3_s3.den == '0);
		b4_d.c.ovf  = (mag4 >= {1'b0, b3_s3.den, 1'b0});
		case (b3_s3.f.func)
			ola_pkg::FN_ADD: b4_d.c.range = b3_s3.f.add_oor;
			ola_pkg::FN_SUB: b4_d.c.range = n4[R-1] || (b3_s3.f.ab < b3_s3.f.bb)
				|| (b3_s3.f.aa < b3_s3.f.ba);
			default:         b4_d.c.range = 1'b0;
		endcase
		b4_d.r = mag4;
		b4_d.q = '0;
	end

	// stage 5: assemble raw result, saturate, zero when not a value result
	always_comb begin
		qc   = dv_s[W].c.ovf ? {1'b1, {W{1'b0}}} : {1'b0, dv_s[W].q};
		qadd = dv_s[W].c.div0 ? '0 : $signed({2'b0, qc});
		qs   = dv_s[W].c.neg ? -qadd : qadd;
		rb   = '0;
		rd   = '0;
		ra   = '0;
		val  = 1'b1;
		case (dv_s[W].c.func)
			ola_pkg::FN_AND: begin
				rb = $signed({2'b0, dv_s[W].c.pbb}) + qadd;
				rd = $signed({3'b0, dv_s[W].c.ad}) + $signed({3'b0, dv_s[W].c.bd})
					- $signed({2'b0, dv_s[W].c.pdd});
				ra = $signed({2'b0, dv_s[W].c.pab});
			end
			ola_pkg::FN_OR: begin
				rd = $signed({2'b0, dv_s[W].c.pdd}) + qadd;
				rb = $signed({3'b0, dv_s[W].c.ab}) + $signed({3'b0, dv_s[W].c.bb})
					- $signed({2'b0, dv_s[W].c.pbb});
				ra = $signed({2'b0, dv_s[W].c.den});
			end
			ola_pkg::FN_ADD: begin
				rb = $signed({3'b0, dv_s[W].c.ab}) + $signed({3'b0, dv_s[W].c.bb});
				rd = qs;
				ra = $signed({2'b0, dv_s[W].c.den});
			end
			ola_pkg::FN_SUB: begin
				rb = $signed({3'b0, dv_s[W].c.ab}) - $signed({3'b0, dv_s[W].c.bb});
				rd = qs;
				ra = $signed({2'b0, dv_s[W].c.den});
			end
			ola_pkg::FN_NEG: begin
				rb = $signed({3'b0, dv_s[W].c.ad});
				rd = $signed({3'b0, dv_s[W].c.ab});
				ra = $signed({3'b0, ola_pkg::ONE}) - $signed({3'b0, dv_s[W].c.aa});
			end
			default: val = 1'b0;
		endcase
		if (dv_s[W].c.range)
			val = 1'b0;
		f1_d.b = val ? ola_pkg::sat_s(rb) : '0;
		f1_d.d = val ? ola_pkg::sat_s(rd) : '0;
		f1_d.a = val ? ola_pkg::sat_s(ra) : '0;
		f1_d.u = val ? ola_pkg::unc(f1_d.b, f1_d.d) : '0;
		f1_d.lt = (dv_s[W].c.func == ola_pkg::FN_CMP) && dv_s[W].c.lt;
		priority if (dv_s[W].c.range)
			f1_d.status = ola_pkg::ST_RANGE;
		else if (dv_s[W].c.div0 && (dv_s[W].c.func == ola_pkg::FN_AND
				|| dv_s[W].c.func == ola_pkg::FN_OR || dv_s[W].c.func == ola_pkg::FN_ADD
				|| dv_s[W].c.func == ola_pkg::FN_SUB))
			f1_d.status = ola_pkg::ST_DIV0;
		else
			f1_d.status = ola_pkg::ST_OK;
	end

	// advance valid bits on the shared enable
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b1_v_s1 <= 1'b0;
			b2_v_s2 <= 1'b0;
			b3_v_s3 <= 1'b0;
			b4_v_s4 <= 1'b0;
			f1_v_s5 <= 1'b0;
			f2_v_s6 <= 1'b0;
			rsp_v_q <= 1'b0;
		end else if (en) begin
			b1_v_s1 <= !q_empty;
			b2_v_s2 <= b1_v_s1;
			b3_v_s3 <= b2_v_s2;
			b4_v_s4 <= b3_v_s3;
			f1_v_s5 <= dv_v[W];
			f2_v_s6 <= f1_v_s5;
			rsp_v_q <= f2_v_s6;
		end
	end

	// advance payload
	always_ff @(posedge clk) begin
		if (en) begin
			b1_s1 <= b1_d;
			b2_s2 <= b2_d;
			b3_s3 <= b3_d;
			b4_s4 <= b4_d;
			f1_s5 <= f1_d;
			f2_s6.v    <= f1_s5;
			f2_s6.prod <= ola_pkg::mul_u({1'b0, f1_s5.a}, {1'b0, f1_s5.u});
			rsp_q.out_belief      <= f2_s6.v.b;
			rsp_q.out_disbelief   <= f2_s6.v.d;
			rsp_q.out_uncertainty <= f2_s6.v.u;
			rsp_q.out_base_rate   <= f2_s6.v.a;
			rsp_q.out_expectation <= ola_pkg::sat_s($signed({3'b0, f2_s6.v.b})
				+ $signed({2'b0, f2_s6.prod}));
			rsp_q.status          <= f2_s6.v.status;
			rsp_q.less_than       <= f2_s6.v.lt;
		end
	end

	// divider: one quotient bit per stage
	for (genvar k = 1; k <= W; k++) begin : g_div
		if (k == 1) begin : g_first
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					dv_v[k] <= 1'b0;
				else if (en)
					dv_v[k] <= b4_v_s4;
			end
			always_ff @(posedge clk) begin
				if (en)
					dv_s[k] <= div_step(b4_s4, 1'b1);
			end
		end else begin : g_next
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					dv_v[k] <= 1'b0;
				else if (en)
					dv_v[k] <= dv_v[k-1];
			end
			always_ff @(posedge clk) begin
				if (en)
					dv_s[k] <= div_step(dv_s[k-1], 1'b0);
			end
		end
	end

	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_v_q && rsp_q.status == ola_pkg::ST_RANGE |->
			rsp_q.out_belief == '0 && rsp_q.out_uncertainty == '0
			&& rsp_q.out_expectation == '0)
		else $error("out-of-range result carries values");

	a_cmp_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_v_q && rsp_q.less_than |->
			rsp_q.status == ola_pkg::ST_OK && rsp_q.out_base_rate == '0)
		else $error("compare result not clean");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_v_q |-> rsp_q.out_belief <= ola_pkg::ONE
			&& rsp_q.out_disbelief <= ola_pkg::ONE
			&& rsp_q.out_expectation <= ola_pkg::ONE)
		else $error("result value above one");

endmodule
`default_nettype wire

/* rtl/opinion_logic_alu_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// opinion_logic_alu_unit: binomial opinion operator unit
// Top level: front intake, decoupling queue and execution pipeline.
// ---------------------------------------------------------------------------
// Takes one request word per cycle while req_stall is low and returns one
// response word per request, in order. Throughput is one word per cycle
// when neither channel stalls. The front register loads on the accepting
// edge; then come the queue write, three product stages and a divider setup
// stage, the 17-stage restoring divider (one quotient bit each) and three
// stages of result assembly, expectation and response register. A stalled
// response holds the whole back pipeline. All operands are unsigned Q1.16
// and values above one are treated as one.
module opinion_logic_alu_unit (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  ola_pkg::req_t      req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output ola_pkg::rsp_t      rsp
);

	ola_pkg::fe_t fe;
	ola_pkg::fe_t q_head;
	logic         q_push;
	logic         q_full;
	logic         q_pop;
	logic         q_empty;

	ola_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req       (req),
		.req_stall (req_stall),
		.q_full    (q_full),
		.q_push    (q_push),
		.fe        (fe)
	);

	ola_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (fe),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_head),
		.empty  (q_empty)
	);

	ola_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire

/* test/opinion_logic_alu_unit_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// opinion_logic_alu_unit_tb: self-checking bench for the opinion operator unit
// Drives directed corner words and random opinion pairs through the request
// channel with random gaps, stalls the response channel at random, and checks
// every response word against an in-bench Q1.16 opinion calculator.
// ---------------------------------------------------------------------------
module opinion_logic_alu_unit_tb;

	localparam longint UNIT = 64'sd1 << 16;
	localparam int WATCHDOG = 4000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	ola_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	ola_pkg::rsp_t rsp;

	int errors = 0;
	int idle_cycles = 0;
	int n_words = 0;
	int n_results = 0;
	int rsp_wait = 0;

	always #6 clk = ~clk;

	opinion_logic_alu_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	// Q1.16 opinion arithmetic, signed 64-bit working values
	function automatic longint clamp1(longint x);
		if (x < 0) return 0;
		if (x > UNIT) return UNIT;
		return x;
	endfunction

	function automatic longint absval(longint x);
		return (x < 0) ? -x : x;
	endfunction

	function automatic longint fxmul(longint x, longint y);
		longint p;
		p = (absval(x) * absval(y)) >>> 16;
		return ((x < 0) != (y < 0)) ? -p : p;
	endfunction

	function automatic longint fxdiv(longint n, longint d);
		longint q;
		q = (absval(n) << 16) / d;
		if (q > 4 * UNIT) q = 4 * UNIT;
		return (n < 0) ? -q : q;
	endfunction

	function automatic longint uncert(longint b, longint d);
		return clamp1(UNIT - b - d);
	endfunction

	function automatic ola_pkg::rsp_t apply_operator(ola_pkg::req_t r);
		ola_pkg::rsp_t o;
		longint ab, ad, aa, bb, bd, ba, au, bu, rb, rd, ra, n, den, ea, eb, b, d, a, u, e;
		logic [1:0] st;
		bit lt, val;
		ab = clamp1(r.a_belief);  ad = clamp1(r.a_disbelief); aa = clamp1(r.a_base_rate);
		bb = clamp1(r.b_belief);  bd = clamp1(r.b_disbelief); ba = clamp1(r.b_base_rate);
		au = uncert(ab, ad); bu = uncert(bb, bd);
		rb = 0; rd = 0; ra = 0; st = ola_pkg::ST_OK; lt = 1'b0; val = 1'b1;
		case (r.func)
			ola_pkg::FN_AND: begin
				n = fxmul(fxmul(fxmul(UNIT - aa, ba), ab), bu)
					+ fxmul(fxmul(fxmul(aa, UNIT - ba), au), bb);
				den = UNIT - fxmul(aa, ba);
				rb = fxmul(ab, bb);
				if (den > 0) rb += fxdiv(n, den); else st = ola_pkg::ST_DIV0;
				rd = ad + bd - fxmul(ad, bd);
				ra = fxmul(aa, ba);
			end
			ola_pkg::FN_OR: begin
				n = fxmul(fxmul(fxmul(aa, UNIT - ba), ad), bu)
					+ fxmul(fxmul(fxmul(UNIT - aa, ba), au), bd);
				den = aa + ba - fxmul(aa, ba);
				rd = fxmul(ad, bd);
				if (den > 0) rd += fxdiv(n, den); else st = ola_pkg::ST_DIV0;
				rb = ab + bb - fxmul(ab, bb);
				ra = den;
			end
			ola_pkg::FN_ADD: begin
				if (aa + ba > UNIT || ab + bb > UNIT) begin
					st = ola_pkg::ST_RANGE; val = 1'b0;
				end else begin
					n = fxmul(aa, ad - bb) + fxmul(ba, bd - ab);
					den = aa + ba;
					rb = ab + bb;
					if (den > 0) rd = fxdiv(n, den); else st = ola_pkg::ST_DIV0;
					ra = den;
				end
			end
			ola_pkg::FN_SUB: begin
				n = fxmul(aa, ad + bb) - fxmul(ba, UNIT + bb - ab - bu);
				if (n < 0 || ab < bb || aa < ba) begin
					st = ola_pkg::ST_RANGE; val = 1'b0;
				end else begin
					den = aa - ba;
					rb = ab - bb;
					if (den > 0) rd = fxdiv(n, den); else st = ola_pkg::ST_DIV0;
					ra = den;
				end
			end
			ola_pkg::FN_NEG: begin
				rb = ad; rd = ab; ra = UNIT - aa;
			end
			ola_pkg::FN_CMP: begin
				ea = ab + fxmul(aa, au);
				eb = bb + fxmul(ba, bu);
				if (ea != eb) lt = (ea < eb);
				else if (au != bu) lt = (au > bu);
				else lt = (aa > ba);
				val = 1'b0;
			end
			default: val = 1'b0;
		endcase
		o = '0;
		if (val) begin
			b = clamp1(rb); d = clamp1(rd); a = clamp1(ra);
			u = uncert(b, d);
			e = clamp1(b + fxmul(a, u));
			o.out_belief = b[16:0];
			o.out_disbelief = d[16:0];
			o.out_uncertainty = u[16:0];
			o.out_base_rate = a[16:0];
			o.out_expectation = e[16:0];
		end
		o.status = st;
		o.less_than = lt;
		return o;
	endfunction

	class opinion_scoreboard;
		ola_pkg::rsp_t pending[$];

		function void note_request(ola_pkg::req_t r);
			pending.push_back(apply_operator(r));
		endfunction

		function int check_response(ola_pkg::rsp_t got);
			ola_pkg::rsp_t exp_w;
			int bad;
			bad = 0;
			if (pending.size() == 0) begin
				$display("%0t: response word with nothing pending: %h", $time, got);
				return 1;
			end
			exp_w = pending.pop_front();
			if (got.out_belief !== exp_w.out_belief) begin
				$display("%0t: belief exp %h got %h", $time, exp_w.out_belief, got.out_belief);
				bad++;
			end
			if (got.out_disbelief !== exp_w.out_disbelief) begin
				$display("%0t: disbelief exp %h got %h", $time,
					exp_w.out_disbelief, got.out_disbelief);
				bad++;
			end
			if (got.out_uncertainty !== exp_w.out_uncertainty) begin
				$display("%0t: uncertainty exp %h got %h", $time,
					exp_w.out_uncertainty, got.out_uncertainty);
				bad++;
			end
			if (got.out_base_rate !== exp_w.out_base_rate) begin
				$display("%0t: base rate exp %h got %h", $time,
					exp_w.out_base_rate, got.out_base_rate);
				bad++;
			end
			if (got.out_expectation !== exp_w.out_expectation) begin
				$display("%0t: expectation exp %h got %h", $time,
					exp_w.out_expectation, got.out_expectation);
				bad++;
			end
			if (got.status !== exp_w.status) begin
				$display("%0t: status exp %h got %h", $time, exp_w.status, got.status);
				bad++;
			end
			if (got.less_than !== exp_w.less_than) begin
				$display("%0t: less_than exp %b got %b", $time, exp_w.less_than, got.less_than);
				bad++;
			end
			return bad;
		endfunction
	endclass

	opinion_scoreboard sb = new();

	// random field value: mostly in range, sometimes the edges or above one
	function automatic logic [16:0] rand_value();
		case ($urandom_range(0, 9))
			0: return 17'd0;
			1: return 17'h10000;
			2: return 17'($urandom_range(17'h10001, 17'h1FFFF));
			3: return 17'($urandom_range(0, 255));
			default: return 17'($urandom_range(0, 17'h10000));
		endcase
	endfunction

	// well-formed opinion: belief + disbelief within one
	task automatic make_opinion(output logic [16:0] b, output logic [16:0] d,
			output logic [16:0] a);
		b = 17'($urandom_range(0, 17'h10000));
		d = 17'($urandom_range(0, 17'h10000 - b));
		a = 17'($urandom_range(0, 17'h10000));
	endtask

	// send one word after a random gap and hold it until accepted
	task automatic send_word(ola_pkg::req_t r);
		int gap;
		gap = $urandom_range(0, 5);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		sb.note_request(r);
		n_words++;
	endtask

	// drop valid after the last word of a burst
	task automatic release_bus();
		req_valid <= 1'b0;
	endtask

	function automatic ola_pkg::req_t pack_word(logic [2:0] f, logic [16:0] ab,
			logic [16:0] ad, logic [16:0] aa, logic [16:0] bb, logic [16:0] bd,
			logic [16:0] ba);
		ola_pkg::req_t r;
		r.func = f; r.a_belief = ab; r.a_disbelief = ad; r.a_base_rate = aa;
		r.b_belief = bb; r.b_disbelief = bd; r.b_base_rate = ba;
		return r;
	endfunction

	// response side: draw a stall count per word, check on acceptance
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				errors += sb.check_response(rsp);
				n_results++;
				rsp_wait = $urandom_range(0, 5);
			end else if (rsp_valid && rsp_wait > 0) begin
				rsp_wait--;
			end
			rsp_stall <= (rsp_wait != 0);
		end
	end

	// watchdog on cycles with no handshake
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		logic [16:0] ab, ad, aa, bb, bd, ba;
		int k;
		int drain;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners
		send_word(pack_word(ola_pkg::FN_AND, 17'h10000, 17'h0, 17'h10000, 17'h10000, 17'h0,
			17'h10000));
		send_word(pack_word(ola_pkg::FN_AND, 17'h8000, 17'h4000, 17'h8000, 17'h2000, 17'h6000,
			17'h4000));
		send_word(pack_word(ola_pkg::FN_OR, 17'h0, 17'h8000, 17'h0, 17'h0, 17'h4000, 17'h0));
		send_word(pack_word(ola_pkg::FN_OR, 17'h4000, 17'h4000, 17'h3000, 17'h1000, 17'h2000,
			17'hA000));
		send_word(pack_word(ola_pkg::FN_ADD, 17'h2000, 17'h4000, 17'h4000, 17'h3000, 17'h1000,
			17'h4000));
		send_word(pack_word(ola_pkg::FN_ADD, 17'h9000, 17'h0, 17'h4000, 17'h9000, 17'h0,
			17'h4000));
		send_word(pack_word(ola_pkg::FN_ADD, 17'h1000, 17'h1000, 17'hC000, 17'h1000, 17'h0,
			17'hC000));
		send_word(pack_word(ola_pkg::FN_ADD, 17'h1000, 17'h1000, 17'h0, 17'h1000, 17'h2000,
			17'h0));
		send_word(pack_word(ola_pkg::FN_SUB, 17'h8000, 17'h4000, 17'h8000, 17'h2000, 17'h1000,
			17'h2000));
		send_word(pack_word(ola_pkg::FN_SUB, 17'h1000, 17'h0, 17'h8000, 17'h2000, 17'h0,
			17'h2000));
		send_word(pack_word(ola_pkg::FN_SUB, 17'h8000, 17'h1000, 17'h4000, 17'h4000, 17'h1000,
			17'h4000));
		send_word(pack_word(ola_pkg::FN_SUB, 17'h8000, 17'h0, 17'h1000, 17'h0, 17'h0,
			17'h8000));
		send_word(pack_word(ola_pkg::FN_NEG, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h0, 17'h0,
			17'h0));
		send_word(pack_word(ola_pkg::FN_NEG, 17'hC000, 17'hC000, 17'h0, 17'h0, 17'h0, 17'h0));
		send_word(pack_word(ola_pkg::FN_CMP, 17'h4000, 17'h4000, 17'h8000, 17'h4000, 17'h4000,
			17'h8000));
		send_word(pack_word(ola_pkg::FN_CMP, 17'h4000, 17'h0, 17'h0, 17'h4000, 17'h4000,
			17'h0));
		send_word(pack_word(ola_pkg::FN_CMP, 17'h4000, 17'h4000, 17'h9000, 17'h4000, 17'h4000,
			17'h1000));
		send_word(pack_word(ola_pkg::FN_CMP, 17'h2000, 17'h1000, 17'h1000, 17'h8000, 17'h1000,
			17'h1000));
		send_word(pack_word(3'd6, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF,
			17'h1FFFF));
		send_word(pack_word(ola_pkg::FN_NONE, 17'h1234, 17'h55, 17'hFFFF, 17'h1, 17'h2,
			17'h3));

		// hold off until the pipeline is empty
		release_bus();
		do @(posedge clk); while (sb.pending.size() != 0);

		// random: mostly well-formed opinions, some raw field noise
		for (k = 0; k < 1500; k++) begin
			if ($urandom_range(0, 3) != 0) begin
				make_opinion(ab, ad, aa);
				make_opinion(bb, bd, ba);
			end else begin
				ab = rand_value(); ad = rand_value(); aa = rand_value();
				bb = rand_value(); bd = rand_value(); ba = rand_value();
			end
			send_word(pack_word((k % 8 == 7) ? 3'($urandom_range(0, 7))
				: 3'($urandom_range(0, 5)), ab, ad, aa, bb, bd, ba));
			if (k == 700) begin
				release_bus();
				do @(posedge clk); while (sb.pending.size() != 0);
			end
		end
		release_bus();

		drain = 0;
		while (sb.pending.size() != 0 && drain < 100000) begin
			@(posedge clk);
			drain++;
		end
		repeat (40) @(posedge clk);
		if (sb.pending.size() != 0) begin
			$display("%0t: %0d response words never arrived", $time, sb.pending.size());
			errors++;
		end
		$display("Sent %0d words over all operators, corners and out-of-range fields;",
			n_words);
		$display("checked %0d responses under random gaps and stalls.", n_results);
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
